FILE: rtl/hedc_pkg.sv
// shared types, constants and helpers for the html entity decoder
// no dependencies; used by every module of the block except hedc_ram

package hedc_pkg;

    localparam int TOKEN_DEPTH = 32;
    localparam int MAX_RESULTS = 32;
    localparam int CAPACITY    = (TOKEN_DEPTH < MAX_RESULTS) ? TOKEN_DEPTH : MAX_RESULTS;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int LEN_W       = $clog2(CAPACITY + 1);

    localparam int SLOTS       = 2;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int RAM_DEPTH   = SLOTS * CAPACITY;
    localparam int RAM_AW      = $clog2(RAM_DEPTH);

    localparam int CODE_W      = 21;
    localparam logic [CODE_W-1:0] CODE_MAX = 21'h10FFFF;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LF   = 8'h66;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UF   = 8'h46;
    localparam logic [7:0] CH_LX   = 8'h78;
    localparam logic [7:0] CH_UX   = 8'h58;

    localparam int NAMES    = 6;
    localparam int NAME_MAX = 6;

    // amp, lt, gt, quot, apos, nbsp
    localparam logic [7:0] NAME_TEXT [NAMES][NAME_MAX] = '{
        '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
        '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
        '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
        '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},
        '{8'h26, 8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B},
        '{8'h26, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B}
    };
    localparam logic [2:0] NAME_LEN [NAMES] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd6, 3'd6};
    localparam logic [7:0] NAME_VALUE [NAMES] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27, 8'h20};

    typedef enum logic [1:0] {
        JOB_ECHO,
        JOB_NAMED,
        JOB_NUMERIC
    } job_kind_t;

    // one finished token waiting for the back end
    typedef struct packed {
        job_kind_t         kind;
        logic [CODE_W-1:0] value;
        logic [LEN_W-1:0]  len;
        logic              cut;
    } job_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_EMIT
    } back_state_t;

    // each queue slot owns one bank of the token store
    function automatic logic [RAM_AW-1:0] slot_addr(input logic [SLOT_W-1:0] slot,
                                                    input logic [IDX_W-1:0] idx);
        logic [RAM_AW-1:0] base;
        base = RAM_AW'(slot) * RAM_AW'(CAPACITY);
        return base + RAM_AW'(idx);
    endfunction

endpackage

FILE: rtl/hedc_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies

module hedc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/hedc_front.sv
// front end: takes token bytes, stores them and checks named and numeric forms
// depends on hedc_pkg; writes the token store and pushes jobs into hedc_queue

module hedc_front
    import hedc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic [7:0]        char_in,
    input  logic              token_end,
    input  logic              full,
    input  logic [SLOT_W-1:0] wr_slot,
    output logic              push,
    output job_t              push_job,
    output logic              mem_we,
    output logic [RAM_AW-1:0] mem_waddr,
    output logic [7:0]        mem_wdata
);

    logic [LEN_W-1:0]  len_reg, len_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic              hex_reg, hex_next;
    logic              nok_reg, nok_next;
    logic [NAMES-1:0]  mask_reg, mask_next;
    logic              cut_reg, cut_next;

    logic              accept;
    logic              fits;
    logic              is_dec, is_hex_lo, is_hex_up, digit_ok;
    logic [7:0]        diff;
    logic [3:0]        digit;
    logic [25:0]       prod, sum;
    logic              over;

    assign item_ready = !full;
    assign accept     = item_valid && !full;
    assign fits       = len_reg < LEN_W'(CAPACITY);

    assign mem_we    = accept && fits;
    assign mem_waddr = slot_addr(wr_slot, len_reg[IDX_W-1:0]);
    assign mem_wdata = char_in;

    // digit value and the candidate accumulator value
    always_comb
    begin
        is_dec    = (char_in >= CH_0) && (char_in <= CH_9);
        is_hex_lo = hex_reg && (char_in >= CH_LA) && (char_in <= CH_LF);
        is_hex_up = hex_reg && (char_in >= CH_UA) && (char_in <= CH_UF);
        digit_ok  = is_dec || is_hex_lo || is_hex_up;
        if (is_dec)
        begin
            diff = char_in - CH_0;
        end
        else if (is_hex_lo)
        begin
            diff = char_in - CH_LA + 8'd10;
        end
        else
        begin
            diff = char_in - CH_UA + 8'd10;
        end
        digit = diff[3:0];
        prod  = hex_reg ? {1'b0, code_reg, 4'b0}
                        : ({2'b0, code_reg, 3'b0} + {4'b0, code_reg, 1'b0});
        sum   = prod + 26'(digit);
        over  = sum > 26'(CODE_MAX);
    end

    always_comb
    begin
        logic found;
        len_next  = len_reg;
        code_next = code_reg;
        hex_next  = hex_reg;
        nok_next  = nok_reg;
        mask_next = mask_reg;
        cut_next  = cut_reg;
        found     = 1'b0;
        push      = accept && token_end;
        push_job  = '0;

        if (accept)
        begin
            if (fits)
            begin
                len_next = len_reg + LEN_W'(1);
                for (int k = 0; k < NAMES; k++)
                begin
                    if (len_reg >= LEN_W'(NAME_LEN[k]))
                    begin
                        mask_next[k] = 1'b0;
                    end
                    else if (NAME_TEXT[k][len_reg[2:0]] != char_in)
                    begin
                        mask_next[k] = 1'b0;
                    end
                end
                if (len_reg == LEN_W'(0))
                begin
                    if (char_in != CH_AMP)
                    begin
                        nok_next = 1'b0;
                    end
                end
                else if (len_reg == LEN_W'(1))
                begin
                    if (char_in != CH_HASH)
                    begin
                        nok_next = 1'b0;
                    end
                end
                else if (!token_end)
                begin
                    if (len_reg == LEN_W'(2) && (char_in == CH_LX || char_in == CH_UX))
                    begin
                        hex_next = 1'b1;
                    end
                    else if (!digit_ok)
                    begin
                        nok_next = 1'b0;
                    end
                    else if (nok_reg)
                    begin
                        if (over)
                        begin
                            nok_next = 1'b0;
                        end
                        else
                        begin
                            code_next = sum[CODE_W-1:0];
                        end
                    end
                end
                if (token_end)
                begin
                    if (char_in != CH_SEMI || len_reg < LEN_W'(3)
                        || (hex_reg && len_reg < LEN_W'(4)))
                    begin
                        nok_next = 1'b0;
                    end
                end
            end
            else
            begin
                cut_next = 1'b1;
            end
        end

        // classify the finished token
        push_job.kind  = JOB_ECHO;
        push_job.value = code_next;
        push_job.len   = len_next;
        push_job.cut   = cut_next;
        if (!cut_next)
        begin
            for (int k = 0; k < NAMES; k++)
            begin
                if (!found && mask_next[k] && len_next == LEN_W'(NAME_LEN[k]))
                begin
                    found          = 1'b1;
                    push_job.kind  = JOB_NAMED;
                    push_job.value = CODE_W'(NAME_VALUE[k]);
                end
            end
            if (!found && nok_next && len_next > LEN_W'(3))
            begin
                push_job.kind = JOB_NUMERIC;
            end
        end

        if (push)
        begin
            len_next  = '0;
            code_next = '0;
            hex_next  = 1'b0;
            nok_next  = 1'b1;
            mask_next = '1;
            cut_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            code_reg <= '0;
            hex_reg  <= 1'b0;
            nok_reg  <= 1'b1;
            mask_reg <= '1;
            cut_reg  <= 1'b0;
        end
        else
        begin
            len_reg  <= len_next;
            code_reg <= code_next;
            hex_reg  <= hex_next;
            nok_reg  <= nok_next;
            mask_reg <= mask_next;
            cut_reg  <= cut_next;
        end
    end

endmodule

FILE: rtl/hedc_queue.sv
// two-slot job queue between front and back end
// depends on hedc_pkg; slot index doubles as the token store bank

module hedc_queue
    import hedc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  job_t              push_job,
    input  logic              pop,
    output logic              full,
    output logic              empty,
    output job_t              head,
    output logic [SLOT_W-1:0] wr_slot,
    output logic [SLOT_W-1:0] rd_slot
);

    job_t              slot_reg [SLOTS];
    logic [SLOT_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [SLOT_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full    = count_reg == CNT_W'(SLOTS);
    assign empty   = count_reg == CNT_W'(0);
    assign head    = slot_reg[rd_ptr_reg];
    assign wr_slot = wr_ptr_reg;
    assign rd_slot = rd_ptr_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == SLOT_W'(SLOTS - 1)) ? '0 : wr_ptr_reg + SLOT_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == SLOT_W'(SLOTS - 1)) ? '0 : rd_ptr_reg + SLOT_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("job popped from an empty queue");

endmodule

FILE: rtl/hedc_back.sv
// back end: turns the head job into output words, utf-8 or echoed bytes
// depends on hedc_pkg; reads the token store and the head of hedc_queue

module hedc_back
    import hedc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  job_t              head,
    input  logic [SLOT_W-1:0] rd_slot,
    output logic              pop,
    output logic [RAM_AW-1:0] mem_raddr,
    input  logic [7:0]        mem_rdata,
    output logic              result_valid,
    input  logic              result_ready,
    output logic [7:0]        byte_out,
    output logic              run_end,
    output logic              was_decoded,
    output logic              overflowed
);

    back_state_t      state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             end_reg, end_next;
    logic             dec_reg, dec_next;
    logic             cut_reg, cut_next;

    logic [LEN_W-1:0] nbytes;
    logic [7:0]       cur_byte;
    logic [7:0]       lead;
    logic [5:0]       group;
    logic [1:0]       grp;
    logic             last_byte;
    logic             load;

    // byte count and current byte of the job
    always_comb
    begin
        unique case (head.kind)
            JOB_NAMED:
            begin
                nbytes = LEN_W'(1);
            end
            JOB_NUMERIC:
            begin
                if (head.value <= CODE_W'(21'h7F))
                begin
                    nbytes = LEN_W'(1);
                end
                else if (head.value <= CODE_W'(21'h7FF))
                begin
                    nbytes = LEN_W'(2);
                end
                else if (head.value <= CODE_W'(21'hFFFF))
                begin
                    nbytes = LEN_W'(3);
                end
                else
                begin
                    nbytes = LEN_W'(4);
                end
            end
            default:
            begin
                nbytes = head.len;
            end
        endcase

        // utf-8 lead byte by sequence length
        case (nbytes[2:0])
            3'd1:    lead = {1'b0, head.value[6:0]};
            3'd2:    lead = {3'b110, head.value[10:6]};
            3'd3:    lead = {4'b1110, head.value[15:12]};
            default: lead = {5'b11110, head.value[20:18]};
        endcase

        // six-bit group counted from the low end
        grp = 2'(nbytes[1:0] - 2'd1 - idx_reg[1:0]);
        case (grp)
            2'd0:    group = head.value[5:0];
            2'd1:    group = head.value[11:6];
            2'd2:    group = head.value[17:12];
            default: group = 6'(head.value[20:18]);
        endcase

        unique case (head.kind)
            JOB_NAMED:   cur_byte = head.value[7:0];
            JOB_NUMERIC: cur_byte = (idx_reg == IDX_W'(0)) ? lead : {2'b10, group};
            default:     cur_byte = mem_rdata;
        endcase

        last_byte = (LEN_W'(idx_reg) + LEN_W'(1)) == nbytes;
    end

    assign load = (state_reg == BACK_EMIT) && (!valid_reg || result_ready);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg && !result_ready;
        byte_next  = byte_reg;
        end_next   = end_reg;
        dec_next   = dec_reg;
        cut_next   = cut_reg;
        pop        = 1'b0;
        mem_raddr  = slot_addr(rd_slot, idx_reg);

        unique case (state_reg)
            BACK_IDLE:
            begin
                mem_raddr = slot_addr(rd_slot, '0);
                if (!empty)
                begin
                    state_next = BACK_EMIT;
                    idx_next   = '0;
                end
            end
            BACK_EMIT:
            begin
                if (load)
                begin
                    valid_next = 1'b1;
                    byte_next  = cur_byte;
                    end_next   = last_byte;
                    dec_next   = head.kind != JOB_ECHO;
                    cut_next   = (head.kind == JOB_ECHO) && head.cut;
                    if (last_byte)
                    begin
                        pop        = 1'b1;
                        state_next = BACK_IDLE;
                    end
                    else
                    begin
                        idx_next  = idx_reg + IDX_W'(1);
                        // fetch ahead so the store data lines up with the index
                        mem_raddr = slot_addr(rd_slot, idx_next);
                    end
                end
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BACK_IDLE;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        end_reg  <= end_next;
        dec_reg  <= dec_next;
        cut_reg  <= cut_next;
    end

    assign result_valid = valid_reg;
    assign byte_out     = byte_reg;
    assign run_end      = end_reg;
    assign was_decoded  = dec_reg;
    assign overflowed   = cut_reg;

    a_emit_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BACK_EMIT) |-> !empty)
        else $error("back end emitting without a queued job");

    a_decoded_not_cut: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && dec_reg) |-> !cut_reg)
        else $error("decoded word marked as truncated");

endmodule

FILE: rtl/html_entity_to_utf8_decoder.sv
// html entity decoder. Token bytes are accepted one word per cycle while
// the two-slot job queue has room; each slot owns one bank of the token store,
// so a second token can be taken in while the first is still being output.
// When both slots hold finished tokens the input stalls until the back end
// frees one. A token's output is 1 word for a named reference, 1 to 4 words
// for a numeric one and the stored length for an echo; the back end starts
// each token from its idle state, and a word moves on only with the output
// register ready. No clearing pass after reset.
// depends on hedc_pkg, hedc_front, hedc_queue, hedc_back and hedc_ram

module html_entity_to_utf8_decoder
    import hedc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [7:0] char_in,
    input  logic       token_end,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] byte_out,
    output logic       run_end,
    output logic       was_decoded,
    output logic       overflowed
);

    logic              full, empty, push, pop;
    job_t              push_job, head;
    logic [SLOT_W-1:0] wr_slot, rd_slot;
    logic              mem_we;
    logic [RAM_AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]        mem_wdata, mem_rdata;

    hedc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .char_in    (char_in),
        .token_end  (token_end),
        .full       (full),
        .wr_slot    (wr_slot),
        .push       (push),
        .push_job   (push_job),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata)
    );

    hedc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (full),
        .empty    (empty),
        .head     (head),
        .wr_slot  (wr_slot),
        .rd_slot  (rd_slot)
    );

    hedc_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    hedc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .head         (head),
        .rd_slot      (rd_slot),
        .pop          (pop),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .byte_out     (byte_out),
        .run_end      (run_end),
        .was_decoded  (was_decoded),
        .overflowed   (overflowed)
    );

endmodule

FILE: test/tb_html_entity_to_utf8_decoder.sv
// testbench for html_entity_to_utf8_decoder: drives entity tokens one byte per word
// and checks every output word against a cycle-free decoder model kept in a scoreboard
// depends on hedc_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb_html_entity_to_utf8_decoder
    import hedc_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int SEND_TARGET = 470;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       decoded;
        logic       cut;
    } out_word_t;

    typedef enum {
        TOK_NAMED,
        TOK_DECIMAL,
        TOK_HEX,
        TOK_BROKEN,
        TOK_LONG,
        TOK_NOISE
    } tok_kind_t;

    typedef enum {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_CADENCE
    } rx_mode_t;

    class entity_decode_scoreboard;
        logic [7:0]        token_bytes [CAPACITY];
        int unsigned       tok_len;
        int unsigned       code_acc;
        bit                hex_ref;
        bit                num_ok;
        bit [NAMES-1:0]    name_hits;
        bit                cut_seen;
        out_word_t         pending_bytes [$];
        int                mismatches;

        function new();
            mismatches = 0;
            restart_token();
        endfunction

        function void restart_token();
            tok_len = 0;
            code_acc = 0;
            hex_ref = 1'b0;
            num_ok = 1'b1;
            name_hits = '1;
            cut_seen = 1'b0;
        endfunction

        function void queue_word(logic [7:0] data, logic run_end, logic decoded, logic cut);
            out_word_t w;
            w.data = data;
            w.run_end = run_end;
            w.decoded = decoded;
            w.cut = cut;
            pending_bytes.insert(pending_bytes.size(), w);
        endfunction

        // byte between the '#' and the final one: base prefix or a digit
        function void add_digit(int unsigned pos, logic [7:0] c);
            int unsigned base;
            int unsigned digit;
            if (pos == 2 && (c == CH_LX || c == CH_UX))
            begin
                hex_ref = 1'b1;
                return;
            end
            base = hex_ref ? 16 : 10;
            if (c >= CH_0 && c <= CH_9)
                digit = c - CH_0;
            else if (hex_ref && c >= CH_LA && c <= CH_LF)
                digit = 10 + (c - CH_LA);
            else if (hex_ref && c >= CH_UA && c <= CH_UF)
                digit = 10 + (c - CH_UA);
            else
            begin
                num_ok = 1'b0;
                return;
            end
            if (!num_ok)
                return;
            // overflow is caught before the digit goes in
            if (code_acc > (int'(CODE_MAX) - digit) / base)
            begin
                num_ok = 1'b0;
                return;
            end
            code_acc = code_acc * base + digit;
        endfunction

        function void emit_utf8(logic [20:0] cp);
            if (cp <= 21'h7F)
                queue_word(cp[7:0], 1'b1, 1'b1, 1'b0);
            else if (cp <= 21'h7FF)
            begin
                queue_word(8'hC0 | {3'b0, cp[10:6]}, 1'b0, 1'b1, 1'b0);
                queue_word(8'h80 | {2'b0, cp[5:0]}, 1'b1, 1'b1, 1'b0);
            end
            else if (cp <= 21'hFFFF)
            begin
                queue_word(8'hE0 | {4'b0, cp[15:12]}, 1'b0, 1'b1, 1'b0);
                queue_word(8'h80 | {2'b0, cp[11:6]}, 1'b0, 1'b1, 1'b0);
                queue_word(8'h80 | {2'b0, cp[5:0]}, 1'b1, 1'b1, 1'b0);
            end
            else
            begin
                queue_word(8'hF0 | {5'b0, cp[20:18]}, 1'b0, 1'b1, 1'b0);
                queue_word(8'h80 | {2'b0, cp[17:12]}, 1'b0, 1'b1, 1'b0);
                queue_word(8'h80 | {2'b0, cp[11:6]}, 1'b0, 1'b1, 1'b0);
                queue_word(8'h80 | {2'b0, cp[5:0]}, 1'b1, 1'b1, 1'b0);
            end
        endfunction

        // one accepted input word; the final word of a token yields its output run
        function void note_char(logic [7:0] c, logic last);
            int unsigned pos;
            bit emitted;
            pos = tok_len;
            if (pos < CAPACITY)
            begin
                token_bytes[pos] = c;
                tok_len = pos + 1;
                for (int k = 0; k < NAMES; k++)
                begin
                    if (pos >= NAME_LEN[k])
                        name_hits[k] = 1'b0;
                    else if (NAME_TEXT[k][pos] != c)
                        name_hits[k] = 1'b0;
                end
                if (pos == 0)
                begin
                    if (c != CH_AMP)
                        num_ok = 1'b0;
                end
                else if (pos == 1)
                begin
                    if (c != CH_HASH)
                        num_ok = 1'b0;
                end
                else if (!last)
                    add_digit(pos, c);
                if (last && (c != CH_SEMI || pos < 3 || (hex_ref && pos < 4)))
                    num_ok = 1'b0;
            end
            else
                cut_seen = 1'b1;

            if (!last)
                return;

            emitted = 1'b0;
            if (!cut_seen)
            begin
                for (int k = 0; k < NAMES; k++)
                begin
                    if (!emitted && name_hits[k] && tok_len == NAME_LEN[k])
                    begin
                        queue_word(NAME_VALUE[k], 1'b1, 1'b1, 1'b0);
                        emitted = 1'b1;
                    end
                end
                if (!emitted && num_ok && tok_len > 3)
                begin
                    emit_utf8(code_acc[20:0]);
                    emitted = 1'b1;
                end
            end
            // anything not decoded goes back out as stored, with the cut flag if it overflowed
            if (!emitted)
            begin
                for (int k = 0; k < tok_len; k++)
                    queue_word(token_bytes[k], (k + 1 == tok_len), 1'b0, cut_seen);
            end
            restart_token();
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 100)
                $display("%0t mismatch: %s", $time, what);
        endtask

        task check_byte(logic [7:0] data, logic run_end, logic decoded, logic cut);
            out_word_t w;
            if (pending_bytes.size() == 0)
            begin
                report($sformatf("unexpected word %02h", data));
                return;
            end
            w = pending_bytes.pop_front();
            if (data !== w.data)
                report($sformatf("byte_out %02h, want %02h", data, w.data));
            if (run_end !== w.run_end)
                report($sformatf("run_end %b, want %b (byte %02h)", run_end, w.run_end,
                                 w.data));
            if (decoded !== w.decoded)
                report($sformatf("was_decoded %b, want %b (byte %02h)", decoded, w.decoded,
                                 w.data));
            if (cut !== w.cut)
                report($sformatf("overflowed %b, want %b (byte %02h)", cut, w.cut, w.data));
        endtask
    endclass

    logic       clk;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_ready;
    logic [7:0] char_in = 8'h00;
    logic       token_end = 1'b0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    logic [7:0] byte_out;
    logic       run_end;
    logic       was_decoded;
    logic       overflowed;

    entity_decode_scoreboard tracker;
    logic [7:0]  token_text [$];
    int          burst_left = 0;
    int          sent_count = 0;
    int          cycles = 0;
    rx_mode_t    rx_mode = RX_OPEN;
    int          rx_left = 0;
    int unsigned rx_phase = 0;

    html_entity_to_utf8_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .char_in      (char_in),
        .token_end    (token_end),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .byte_out     (byte_out),
        .run_end      (run_end),
        .was_decoded  (was_decoded),
        .overflowed   (overflowed)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("html_entity_to_utf8_decoder test failed");
            $finish;
        end
    end

    // receiver back-pressure, switching between a few stall patterns
    always @(posedge clk)
    begin
        rx_phase <= rx_phase + 1;
        if (rx_left == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 200);
        end
        else
            rx_left <= rx_left - 1;
        case (rx_mode)
            RX_OPEN:    result_ready <= 1'b1;
            RX_COIN:    result_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE:  result_ready <= ($urandom_range(0, 3) == 0);
            default:    result_ready <= (rx_phase % 5 < 3);
        endcase
    end

    // handshake state is settled at the falling edge; the word moves at the next rise
    always @(negedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            tracker.check_byte(byte_out, run_end, was_decoded, overflowed);
    end

    task automatic push_byte(input logic [7:0] c, input logic last);
        if (burst_left == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 20);
        end
        burst_left--;
        item_valid <= 1'b1;
        char_in <= c;
        token_end <= last;
        @(negedge clk);
        while (!item_ready) @(negedge clk);
        @(posedge clk);
        tracker.note_char(c, last);
        sent_count++;
    endtask

    task automatic send_token();
        for (int i = 0; i < token_text.size(); i++)
            push_byte(token_text[i], i == token_text.size() - 1);
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        while (tracker.pending_bytes.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    function automatic void append_byte(logic [7:0] b);
        token_text.insert(token_text.size(), b);
    endfunction

    function automatic void drop_last();
        token_text.delete(token_text.size() - 1);
    endfunction

    function automatic void load_text(string s);
        token_text.delete();
        for (int i = 0; i < s.len(); i++)
            append_byte(s[i]);
    endfunction

    function automatic void add_name(int k);
        for (int i = 0; i < NAME_LEN[k]; i++)
            append_byte(NAME_TEXT[k][i]);
    endfunction

    function automatic void add_number(bit hex);
        int unsigned v;
        int unsigned edges [9] = '{0, 'h7F, 'h80, 'h7FF, 'h800, 'hFFFF, 'h10000,
                                   'h10FFFF, 'h110000};
        string digits;
        int zeros;
        logic [7:0] ch;
        case ($urandom_range(0, 6))
            0: v = $urandom_range(0, 'h7F);
            1: v = $urandom_range('h80, 'h7FF);
            2: v = $urandom_range('h800, 'hFFFF);
            3: v = $urandom_range('hD800, 'hDFFF);
            4: v = $urandom_range('h10000, 'h10FFFF);
            5: v = edges[$urandom_range(0, 8)];
            default: v = $urandom_range('h110000, 'hFFFFFFFF);
        endcase
        append_byte(CH_AMP);
        append_byte(CH_HASH);
        if (hex)
            append_byte($urandom_range(0, 1) ? CH_LX : CH_UX);
        zeros = 0;
        if ($urandom_range(0, 3) == 0)
            zeros = $urandom_range(1, 4);
        if ($urandom_range(0, 15) == 0)
            zeros = $urandom_range(18, 28);
        repeat (zeros) append_byte(CH_0);
        digits = hex ? $sformatf("%0h", v) : $sformatf("%0d", v);
        for (int i = 0; i < digits.len(); i++)
        begin
            ch = digits[i];
            if (ch >= CH_LA && $urandom_range(0, 1))
                ch = ch - 8'h20;
            append_byte(ch);
        end
        append_byte(CH_SEMI);
    endfunction

    function automatic void build_token(tok_kind_t kind);
        int n;
        int spot;
        token_text.delete();
        case (kind)
            TOK_NAMED:   add_name($urandom_range(0, NAMES - 1));
            TOK_DECIMAL: add_number(1'b0);
            TOK_HEX:     add_number(1'b1);
            TOK_BROKEN:
            begin
                if ($urandom_range(0, 2) == 0)
                    add_name($urandom_range(0, NAMES - 1));
                else
                    add_number(1'($urandom_range(0, 1)));
                case ($urandom_range(0, 5))
                    0: drop_last();
                    1:
                    begin
                        spot = $urandom_range(0, token_text.size() - 1);
                        token_text[spot] = 8'($urandom_range(0, 255));
                    end
                    2:
                    begin
                        n = $urandom_range(1, token_text.size() - 1);
                        while (token_text.size() > n) drop_last();
                    end
                    3: token_text.insert(token_text.size() - 1, 8'($urandom_range(0, 255)));
                    4: token_text = '{CH_AMP, CH_HASH, CH_LX, CH_SEMI};
                    default: token_text = '{CH_AMP, CH_HASH, CH_SEMI};
                endcase
            end
            TOK_LONG:
            begin
                // around the buffer size: full fit, one over, well over
                n = $urandom_range(CAPACITY, CAPACITY + 8);
                append_byte(CH_AMP);
                repeat (n - 1) append_byte(8'($urandom_range(0, 255)));
            end
            default:
                repeat ($urandom_range(1, 8)) append_byte(8'($urandom_range(0, 255)));
        endcase
    endfunction

    function automatic tok_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return TOK_NAMED;
        else if (r < 45)
            return TOK_DECIMAL;
        else if (r < 65)
            return TOK_HEX;
        else if (r < 85)
            return TOK_BROKEN;
        else if (r < 90)
            return TOK_LONG;
        return TOK_NOISE;
    endfunction

    initial
    begin
        int tokens;
        tracker = new();
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short directed run: plain-space name, zero, top code point, empty number,
        // lone high byte
        load_text("&nbsp;");
        send_token();
        load_text("&#0;");
        send_token();
        load_text("&#X10fFfF;");
        send_token();
        load_text("&#;");
        send_token();
        token_text = '{8'hFF};
        send_token();

        tokens = 0;
        while (sent_count < SEND_TARGET)
        begin
            build_token(pick_kind());
            send_token();
            tokens++;
            // let the output side empty completely now and then
            if (tokens == 10 || $urandom_range(0, 24) == 0)
                drain_results();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("html_entity_to_utf8_decoder test passed");
        else
            $display("html_entity_to_utf8_decoder test failed");
        $finish;
    end

endmodule
